/* hdl/lptt_pkg.sv */
// lptt_pkg: shared types and constants for the linear probe transposition table
// field widths, request and status codes, controller states, command and status bundles
// no dependencies
package lptt_pkg;

    localparam int KEY_W      = 64;
    localparam int DEPTH_W    = 4;
    localparam int SCORE_W    = 32;
    localparam int BOUND_W    = 2;
    localparam int REQ_W      = 2;
    localparam int STATUS_W   = 2;
    localparam int PAYLOAD_W  = DEPTH_W + SCORE_W + BOUND_W;
    localparam int ENTRY_W    = KEY_W + PAYLOAD_W;
    localparam int IN_DATA_W  = ((ENTRY_W + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((PAYLOAD_W + 7) / 8) * 8;

    typedef enum logic [REQ_W-1:0] {
        REQ_LOOKUP = 2'd0,
        REQ_STORE  = 2'd1,
        REQ_CLEAR  = 2'd2
    } req_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK   = 2'd0,
        STAT_MISS = 2'd1,
        STAT_FULL = 2'd2,
        STAT_ZERO = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        ST_BOOT,
        ST_IDLE,
        ST_DECODE,
        ST_READ,
        ST_CHECK,
        ST_CLEAR,
        ST_RESP
    } state_t;

    typedef struct packed {
        logic    load_req;
        logic    sweep_write;
        logic    probe_init;
        logic    probe_read;
        logic    probe_next;
        logic    store_write;
        logic    out_load;
        status_t out_status;
        logic    out_hit;
    } cmd_t;

    typedef struct packed {
        req_t req_type;
        logic key_zero;
        logic hash_done;
        logic slot_empty;
        logic slot_match;
        logic circle_done;
        logic sweep_last;
        logic out_free;
    } dp_status_t;

endpackage

/* hdl/linear_probe_transposition_table.sv */
// linear_probe_transposition_table: open-addressed hash table of search results
// after reset a clear pass over every slot runs with s_axis_tready low
// one request at a time; lookup or store: home slot reduction (a mask when TABLE_DEPTH is a
// power of two, else an iterative remainder), then a slot read and a check per slot probed
// clear: one slot ram write per cycle; the registered slot ram read port puts a read state
// before each check in a probe; uses lptt_pkg, lptt_ctrl, lptt_dp
module linear_probe_transposition_table
    import lptt_pkg::*;
#(
    parameter int TABLE_DEPTH = 4096
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // hash_key, search_depth, score_value, bound_kind, zero fill
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // req_type
    input  logic [REQ_W-1:0]      s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // entry_depth, entry_score, entry_bound, zero fill
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // status
    output logic [STATUS_W-1:0]   m_axis_tuser
);

    cmd_t       cmd;
    dp_status_t stat;

    lptt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    lptt_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (s_axis_tdata),
        .in_user   (s_axis_tuser),
        .cmd       (cmd),
        .stat      (stat),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata),
        .out_user  (m_axis_tuser)
    );

endmodule

/* hdl/lptt_ram.sv */
// lptt_ram: generic single write port, single read port ram with registered read
// no dependencies
module lptt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* hdl/lptt_home.sv */
// lptt_home: home slot unit, key modulo table depth
// a mask for power-of-two depths, else four remainder steps per cycle; uses lptt_pkg
module lptt_home
    import lptt_pkg::*;
#(
    parameter int TABLE_DEPTH = 4096
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [KEY_W-1:0]               key,
    output logic                           done,
    output logic [$clog2(TABLE_DEPTH)-1:0] home
);

    localparam int ADDR_W  = $clog2(TABLE_DEPTH);
    localparam bit IS_POW2 = (TABLE_DEPTH & (TABLE_DEPTH - 1)) == 0;

    if (IS_POW2)
    begin : g_mask
        logic [ADDR_W-1:0] home_reg;
        logic              done_reg;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                done_reg <= 1'b0;
            end
            else if (start)
            begin
                done_reg <= 1'b1;
            end
        end

        always_ff @(posedge clk)
        begin
            if (start)
            begin
                home_reg <= key[ADDR_W-1:0];
            end
        end

        assign done = done_reg;
        assign home = home_reg;
    end
    else
    begin : g_iter
        localparam int STEP_BITS = 4;
        localparam int STEPS     = KEY_W / STEP_BITS;
        localparam int CNT_W     = $clog2(STEPS);
        localparam logic [ADDR_W:0] DEPTH_C = (ADDR_W + 1)'(TABLE_DEPTH);

        logic [KEY_W-1:0]  key_sh_reg;
        logic [ADDR_W-1:0] rem_reg;
        logic [ADDR_W-1:0] rem_next;
        logic [CNT_W-1:0]  cnt_reg;
        logic              busy_reg;
        logic              done_reg;

        // remainder of (rem * 16 + next nibble), one compare and subtract per bit
        always_comb
        begin
            logic [ADDR_W:0] t;
            rem_next = rem_reg;
            for (int k = 0; k < STEP_BITS; k++)
            begin
                t = {rem_next, key_sh_reg[KEY_W-1-k]};
                if (t >= DEPTH_C)
                begin
                    t = t - DEPTH_C;
                end
                rem_next = t[ADDR_W-1:0];
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b0;
                cnt_reg  <= '0;
            end
            else if (start)
            begin
                busy_reg <= 1'b1;
                done_reg <= 1'b0;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (start)
            begin
                key_sh_reg <= key;
                rem_reg    <= '0;
            end
            else if (busy_reg)
            begin
                key_sh_reg <= key_sh_reg << STEP_BITS;
                rem_reg    <= rem_next;
            end
        end

        assign done = done_reg;
        assign home = rem_reg;
    end

endmodule

/* hdl/lptt_dp.sv */
// lptt_dp: datapath, request registers, probe index and counter, slot ram, result register
// uses lptt_pkg, lptt_home and lptt_ram
module lptt_dp
    import lptt_pkg::*;
#(
    parameter int TABLE_DEPTH = 4096
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [IN_DATA_W-1:0]  in_data,
    input  logic [REQ_W-1:0]      in_user,
    input  cmd_t                  cmd,
    output dp_status_t            stat,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [OUT_DATA_W-1:0] out_data,
    output logic [STATUS_W-1:0]   out_user
);

    localparam int ADDR_W = $clog2(TABLE_DEPTH);
    localparam logic [ADDR_W-1:0] LAST_C = ADDR_W'(TABLE_DEPTH - 1);

    req_t                 req_type_reg;
    logic [KEY_W-1:0]     key_reg;
    logic [PAYLOAD_W-1:0] payload_reg;
    logic [ADDR_W-1:0]    idx_reg;
    logic [ADDR_W-1:0]    probe_cnt_reg;
    logic [ADDR_W-1:0]    sweep_addr_reg;
    logic                 out_valid_reg;
    status_t              out_status_reg;
    logic [PAYLOAD_W-1:0] out_payload_reg;

    logic                 hash_done;
    logic [ADDR_W-1:0]    home;
    logic                 wr_en;
    logic [ADDR_W-1:0]    wr_addr;
    logic [ENTRY_W-1:0]   wr_data;
    logic [ENTRY_W-1:0]   rd_data;
    logic [KEY_W-1:0]     slot_key;
    logic                 out_free;

    lptt_home #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_home (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.load_req),
        .key   (in_data[KEY_W-1:0]),
        .done  (hash_done),
        .home  (home)
    );

    // entry layout from bit 0: key, depth, score, bound
    lptt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (cmd.probe_read),
        .rd_addr (idx_reg),
        .rd_data (rd_data)
    );

    always_comb
    begin
        wr_en   = cmd.sweep_write || cmd.store_write;
        wr_addr = cmd.sweep_write ? sweep_addr_reg : idx_reg;
        wr_data = cmd.sweep_write ? '0 : {payload_reg, key_reg};
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            req_type_reg <= req_t'(in_user);
            key_reg      <= in_data[KEY_W-1:0];
            payload_reg  <= in_data[ENTRY_W-1:KEY_W];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg        <= '0;
            probe_cnt_reg  <= '0;
            sweep_addr_reg <= '0;
        end
        else
        begin
            if (cmd.probe_init)
            begin
                idx_reg       <= home;
                probe_cnt_reg <= '0;
            end
            else if (cmd.probe_next)
            begin
                idx_reg       <= (idx_reg == LAST_C) ? '0 : idx_reg + 1'b1;
                probe_cnt_reg <= probe_cnt_reg + 1'b1;
            end
            if (cmd.sweep_write)
            begin
                sweep_addr_reg <= (sweep_addr_reg == LAST_C) ? '0 : sweep_addr_reg + 1'b1;
            end
        end
    end

    // result register, free when empty or being drained this cycle
    assign out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_status_reg  <= cmd.out_status;
            out_payload_reg <= cmd.out_hit ? rd_data[ENTRY_W-1:KEY_W] : '0;
        end
    end

    assign slot_key = rd_data[KEY_W-1:0];

    always_comb
    begin
        stat.req_type    = req_type_reg;
        stat.key_zero    = (key_reg == '0);
        stat.hash_done   = hash_done;
        stat.slot_empty  = (slot_key == '0);
        stat.slot_match  = (slot_key == key_reg);
        stat.circle_done = (probe_cnt_reg == LAST_C);
        stat.sweep_last  = (sweep_addr_reg == LAST_C);
        stat.out_free    = out_free;
    end

    assign out_valid = out_valid_reg;
    assign out_user  = out_status_reg;
    assign out_data  = OUT_DATA_W'(out_payload_reg);

    a_one_writer: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.sweep_write && cmd.store_write))
        else $error("sweep and store write in the same cycle");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> out_free)
        else $error("result register loaded while a beat is pending");

    a_store_target: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.store_write |-> (stat.slot_empty || stat.slot_match))
        else $error("store into an occupied slot of another key");

    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        idx_reg <= LAST_C && sweep_addr_reg <= LAST_C)
        else $error("slot index beyond table depth");

endmodule

/* hdl/lptt_ctrl.sv */
// lptt_ctrl: controller state machine for clear sweeps, probe walks and result hand-off
// uses lptt_pkg
module lptt_ctrl
    import lptt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  dp_status_t stat,
    output cmd_t       cmd
);

    state_t  state_reg;
    state_t  state_next;
    status_t resp_code_reg;
    status_t resp_code_next;
    logic    resp_hit_reg;
    logic    resp_hit_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_BOOT;
            resp_code_reg <= STAT_OK;
            resp_hit_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            resp_code_reg <= resp_code_next;
            resp_hit_reg  <= resp_hit_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        resp_code_next = resp_code_reg;
        resp_hit_next  = resp_hit_reg;
        cmd            = '0;
        cmd.out_status = resp_code_reg;
        cmd.out_hit    = resp_hit_reg;
        in_ready       = 1'b0;
        case (state_reg)
            ST_BOOT:
            begin
                cmd.sweep_write = 1'b1;
                if (stat.sweep_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_req = 1'b1;
                    state_next   = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                case (stat.req_type)
                    REQ_CLEAR:
                    begin
                        state_next = ST_CLEAR;
                    end
                    REQ_LOOKUP, REQ_STORE:
                    begin
                        if (stat.key_zero)
                        begin
                            resp_code_next = STAT_ZERO;
                            resp_hit_next  = 1'b0;
                            state_next     = ST_RESP;
                        end
                        else if (stat.hash_done)
                        begin
                            cmd.probe_init = 1'b1;
                            state_next     = ST_READ;
                        end
                    end
                    default:
                    begin
                        resp_code_next = STAT_OK;
                        resp_hit_next  = 1'b0;
                        state_next     = ST_RESP;
                    end
                endcase
            end
            ST_READ:
            begin
                cmd.probe_read = 1'b1;
                state_next     = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (stat.slot_empty || stat.slot_match)
                begin
                    state_next = ST_RESP;
                    if (stat.req_type == REQ_STORE)
                    begin
                        cmd.store_write = 1'b1;
                        resp_code_next  = STAT_OK;
                        resp_hit_next   = 1'b0;
                    end
                    else
                    begin
                        resp_code_next = stat.slot_match ? STAT_OK : STAT_MISS;
                        resp_hit_next  = stat.slot_match;
                    end
                end
                else if (stat.circle_done)
                begin
                    state_next     = ST_RESP;
                    resp_code_next = (stat.req_type == REQ_STORE) ? STAT_FULL : STAT_MISS;
                    resp_hit_next  = 1'b0;
                end
                else
                begin
                    cmd.probe_next = 1'b1;
                    state_next     = ST_READ;
                end
            end
            ST_CLEAR:
            begin
                cmd.sweep_write = 1'b1;
                if (stat.sweep_last)
                begin
                    resp_code_next = STAT_OK;
                    resp_hit_next  = 1'b0;
                    state_next     = ST_RESP;
                end
            end
            ST_RESP:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    a_probe_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.probe_read |=> state_reg == ST_CHECK)
        else $error("slot read not followed by a check");

    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_req |=> state_reg == ST_DECODE && !in_ready)
        else $error("request taken outside idle");

    a_resp_once: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> state_reg == ST_IDLE && !cmd.out_load)
        else $error("result loaded twice for one request");

endmodule

/* tb/sv/linear_probe_transposition_table_test.sv */
// linear_probe_transposition_table_test: self-checking bench for the transposition table
// drives request beats, predicts every answer from its own copy of the table and checks it
// depends on lptt_pkg and linear_probe_transposition_table
`timescale 1ns / 100ps

module linear_probe_transposition_table_test;
    import lptt_pkg::*;

    localparam int TBL_DEPTH = 4096;
    localparam int SLOT_W    = $clog2(TBL_DEPTH);
    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

    typedef struct packed {
        status_t              status;
        logic [DEPTH_W-1:0]   depth;
        logic [SCORE_W-1:0]   score;
        logic [BOUND_W-1:0]   bound;
    } answer_t;

    logic                  clk;
    logic                  rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic [REQ_W-1:0]      s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [STATUS_W-1:0]   m_axis_tuser;

    // own copy of the table
    logic [KEY_W-1:0]   tbl_key   [TBL_DEPTH];
    logic [DEPTH_W-1:0] tbl_depth [TBL_DEPTH];
    logic [SCORE_W-1:0] tbl_score [TBL_DEPTH];
    logic [BOUND_W-1:0] tbl_bound [TBL_DEPTH];

    logic [KEY_W-1:0]   fill_key  [TBL_DEPTH];
    logic [KEY_W-1:0]   key_pool  [$];
    answer_t            expected_answers [$];
    int                 fail_count = 0;
    int                 ready_hold = 0;
    bit                 idle_off   = 1'b0;

    linear_probe_transposition_table #(
        .TABLE_DEPTH (TBL_DEPTH)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("FAIL");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (idle_off || r < 50)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    function automatic answer_t predict_answer(logic [REQ_W-1:0] kind, logic [KEY_W-1:0] key,
                                               logic [DEPTH_W-1:0] dep, logic [SCORE_W-1:0] sc,
                                               logic [BOUND_W-1:0] bnd);
        answer_t a;
        int      idx;
        int      n;
        bit      done;
        a        = '0;
        a.status = STAT_OK;
        done     = 1'b0;
        if (kind == REQ_CLEAR)
        begin
            for (n = 0; n < TBL_DEPTH; n++)
                tbl_key[n] = '0;
        end
        else if (kind == REQ_LOOKUP || kind == REQ_STORE)
        begin
            if (key == '0)
                a.status = STAT_ZERO;
            else
            begin
                idx = int'(key % TBL_DEPTH);
                if (kind == REQ_LOOKUP)
                    a.status = STAT_MISS;
                else
                    a.status = STAT_FULL;
                for (n = 0; n < TBL_DEPTH && !done; n++)
                begin
                    if (kind == REQ_LOOKUP)
                    begin
                        if (tbl_key[idx] == '0)
                            done = 1'b1;
                        else if (tbl_key[idx] == key)
                        begin
                            done     = 1'b1;
                            a.status = STAT_OK;
                            a.depth  = tbl_depth[idx];
                            a.score  = tbl_score[idx];
                            a.bound  = tbl_bound[idx];
                        end
                    end
                    else if (tbl_key[idx] == '0 || tbl_key[idx] == key)
                    begin
                        done           = 1'b1;
                        a.status       = STAT_OK;
                        tbl_key[idx]   = key;
                        tbl_depth[idx] = dep;
                        tbl_score[idx] = sc;
                        tbl_bound[idx] = bnd;
                    end
                    if (!done)
                        idx = (idx + 1 == TBL_DEPTH) ? 0 : idx + 1;
                end
            end
        end
        return a;
    endfunction

    // random key, half of them homed in the slots around the wrap point
    function automatic logic [KEY_W-1:0] fresh_key();
        logic [KEY_W-1:0] k;
        k = {$urandom, $urandom};
        if ($urandom_range(0, 1) == 1)
            k[SLOT_W-1:0] = SLOT_W'(TBL_DEPTH - 3 + $urandom_range(0, 5));
        if (k == '0)
            k = 64'd1;
        return k;
    endfunction

    task automatic send_req(input logic [REQ_W-1:0] kind, input logic [KEY_W-1:0] key,
                            input logic [DEPTH_W-1:0] dep, input logic [SCORE_W-1:0] sc,
                            input logic [BOUND_W-1:0] bnd);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_DATA_W'({bnd, sc, dep, key});
        s_axis_tuser  <= kind;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        expected_answers.push_back(predict_answer(kind, key, dep, sc, bnd));
    endtask

    always @(posedge clk)
    begin : result_check
        answer_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_answers.size() == 0)
            begin
                $error("result beat with no request waiting: status %0d", m_axis_tuser);
                fail_count++;
            end
            else
            begin
                want = expected_answers.pop_front();
                if (m_axis_tuser !== want.status)
                begin
                    $error("status: expected %0d, actual %0d", want.status, m_axis_tuser);
                    fail_count++;
                end
                if (m_axis_tdata[DEPTH_W-1:0] !== want.depth)
                begin
                    $error("entry_depth: expected %0d, actual %0d", want.depth,
                           m_axis_tdata[DEPTH_W-1:0]);
                    fail_count++;
                end
                if (m_axis_tdata[DEPTH_W+SCORE_W-1:DEPTH_W] !== want.score)
                begin
                    $error("entry_score: expected %0d, actual %0d", $signed(want.score),
                           $signed(m_axis_tdata[DEPTH_W+SCORE_W-1:DEPTH_W]));
                    fail_count++;
                end
                if (m_axis_tdata[PAYLOAD_W-1:DEPTH_W+SCORE_W] !== want.bound)
                begin
                    $error("entry_bound: expected %0d, actual %0d", want.bound,
                           m_axis_tdata[PAYLOAD_W-1:DEPTH_W+SCORE_W]);
                    fail_count++;
                end
            end
        end
        // receiver back-pressure
        if (ready_hold > 0)
        begin
            ready_hold     = ready_hold - 1;
            m_axis_tready <= 1'b0;
        end
        else if (!idle_off && $urandom_range(0, 7) == 0)
        begin
            ready_hold     = pick_gap();
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= 1'b1;
    end

    task automatic test_directed_requests();
        logic [KEY_W-1:0] k_max;
        logic [KEY_W-1:0] k_wrap1;
        logic [KEY_W-1:0] k_wrap2;
        logic [KEY_W-1:0] k_top;
        k_max   = '1;
        k_wrap1 = (64'd1 << SLOT_W) | (TBL_DEPTH - 1);
        k_wrap2 = (64'd2 << SLOT_W) | (TBL_DEPTH - 1);
        k_top   = 64'h8000_0000_0000_0000;
        // zero key rejected on both request kinds
        send_req(REQ_LOOKUP, '0, 4'd3, 32'd5, 2'd1);
        send_req(REQ_STORE, '0, 4'd15, 32'h7FFF_FFFF, 2'd2);
        send_req(REQ_LOOKUP, 64'd1, '0, '0, '0);
        // chain homed in the last slot, wrapping to slot 0
        send_req(REQ_STORE, k_max, 4'd15, 32'h8000_0000, 2'd3);
        send_req(REQ_STORE, k_wrap1, 4'd9, 32'hFFFF_FFFF, 2'd0);
        send_req(REQ_STORE, k_wrap2, 4'd1, 32'd1234, 2'd1);
        send_req(REQ_LOOKUP, k_max, '0, '0, '0);
        send_req(REQ_LOOKUP, k_wrap1, '0, '0, '0);
        send_req(REQ_LOOKUP, k_wrap2, '0, '0, '0);
        send_req(REQ_LOOKUP, (64'd3 << SLOT_W) | (TBL_DEPTH - 1), '0, '0, '0);
        // overwrite in place
        send_req(REQ_STORE, k_wrap1, 4'd0, 32'h7FFF_FFFF, 2'd0);
        send_req(REQ_LOOKUP, k_wrap1, '0, '0, '0);
        // home slots 0 and 1 already taken by the wrapped chain, then a free home slot
        send_req(REQ_STORE, 64'd1, 4'd7, 32'hDEAD_BEEF, 2'd2);
        send_req(REQ_STORE, k_top, 4'd12, 32'h0000_8001, 2'd1);
        send_req(REQ_STORE, 64'd5, 4'd6, 32'hFFFF_0000, 2'd2);
        send_req(REQ_LOOKUP, 64'd1, '0, '0, '0);
        send_req(REQ_LOOKUP, k_top, '0, '0, '0);
        send_req(REQ_LOOKUP, 64'd5, '0, '0, '0);
        // unused request kind leaves the table alone
        send_req(REQ_UNUSED, k_max, 4'd15, 32'hFFFF_FFFF, 2'd3);
        send_req(REQ_LOOKUP, k_max, '0, '0, '0);
        // clear ignores its key
        send_req(REQ_CLEAR, k_max, 4'd15, 32'hFFFF_FFFF, 2'd3);
        send_req(REQ_LOOKUP, k_max, '0, '0, '0);
        send_req(REQ_LOOKUP, 64'd1, '0, '0, '0);
    endtask

    task automatic test_full_table();
        int               i;
        logic [KEY_W-1:0] upper;
        logic [KEY_W-1:0] k_new;
        // fill every slot at its home, no idling
        idle_off = 1'b1;
        for (i = 0; i < TBL_DEPTH; i++)
        begin
            upper = {$urandom, $urandom};
            if (i == 0)
                upper[SLOT_W] = 1'b1;
            fill_key[i] = {upper[KEY_W-1:SLOT_W], SLOT_W'(i)};
            send_req(REQ_STORE, fill_key[i], DEPTH_W'($urandom), $urandom, BOUND_W'($urandom));
        end
        idle_off = 1'b0;
        k_new = fill_key[77] + (64'd1 << SLOT_W);
        send_req(REQ_STORE, k_new, 4'd4, 32'd44, 2'd1);
        send_req(REQ_LOOKUP, k_new, '0, '0, '0);
        send_req(REQ_STORE, fill_key[TBL_DEPTH-1], 4'd15, 32'h8000_0000, 2'd2);
        send_req(REQ_LOOKUP, fill_key[TBL_DEPTH-1], '0, '0, '0);
        send_req(REQ_LOOKUP, fill_key[0], '0, '0, '0);
        send_req(REQ_STORE, '0, 4'd1, 32'd1, 2'd1);
        send_req(REQ_CLEAR, '0, '0, '0, '0);
        send_req(REQ_LOOKUP, fill_key[5], '0, '0, '0);
    endtask

    task automatic test_random_traffic();
        int               n;
        int               r;
        bit               from_pool;
        logic [KEY_W-1:0] key;
        logic [REQ_W-1:0] kind;
        for (n = 0; n < 400; n++)
        begin
            if (n % 50 == 0)
                idle_off = ($urandom_range(0, 3) == 0);
            from_pool = (key_pool.size() != 0 && $urandom_range(0, 9) < 7);
            if (from_pool)
                key = key_pool[$urandom_range(0, key_pool.size() - 1)];
            else
                key = fresh_key();
            r = $urandom_range(0, 99);
            if (r < 42)
                kind = REQ_LOOKUP;
            else if (r < 84)
                kind = REQ_STORE;
            else if (r < 88)
                kind = REQ_CLEAR;
            else if (r < 91)
                kind = REQ_UNUSED;
            else if (r < 96)
            begin
                kind = ($urandom_range(0, 1) == 1) ? REQ_STORE : REQ_LOOKUP;
                key  = '0;
            end
            else
            begin
                kind = REQ_LOOKUP;
                key  = fresh_key();
            end
            if (kind == REQ_STORE && key != '0 && !from_pool)
            begin
                key_pool.push_back(key);
                if (key_pool.size() > 48)
                    void'(key_pool.pop_front());
            end
            send_req(kind, key, DEPTH_W'($urandom), $urandom, BOUND_W'($urandom));
        end
        idle_off = 1'b0;
    endtask

    initial
    begin
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        rst_n         = 1'b0;
        for (int i = 0; i < TBL_DEPTH; i++)
        begin
            tbl_key[i]   = '0;
            tbl_depth[i] = '0;
            tbl_score[i] = '0;
            tbl_bound[i] = '0;
        end
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        test_directed_requests();
        test_full_table();
        test_random_traffic();
        s_axis_tvalid <= 1'b0;
        while (expected_answers.size() != 0)
            @(posedge clk);
        repeat (64) @(posedge clk);
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
